FILE: rtl/lbr_pkg.sv
// Shared types and constants for the branch range extractor.
// Holds the record kind codes and the job format passed from front to back.
package lbr_pkg;

    localparam int unsigned ADDR_W = 64;
    localparam int unsigned SPAN_W = 32;
    localparam int unsigned KIND_W = 3;

    localparam logic [SPAN_W-1:0] SPAN_RESET = 32'd1048576;

    typedef enum logic [KIND_W-1:0] {
        KIND_HOT      = 3'd0,
        KIND_BRANCH   = 3'd1,
        KIND_RANGE    = 3'd2,
        KIND_BOGUS    = 3'd3,
        KIND_ODD      = 3'd4,
        KIND_OVERFLOW = 3'd5
    } kind_t;

    typedef enum logic {
        CFG_SKEW = 1'b0,
        CFG_SPAN = 1'b1
    } cfg_index_t;

    // One queued job: either a single flag record or a branch with its extras.
    typedef struct packed {
        logic              is_branch;
        kind_t             single_kind;
        logic              hot;
        logic              has_range;
        logic [ADDR_W-1:0] addr_a;   // raw address, or branch source
        logic [ADDR_W-1:0] addr_b;   // adjusted branch target
        logic [ADDR_W-1:0] addr_c;   // previous branch source
    } job_t;

endpackage

FILE: rtl/lbr_branch_range_extractor.sv
// Branch range extractor: turns last-branch-record frames into profile
// records. A frame is taken whenever the job queue has room; the back end
// then sends one record per cycle while m_ready is high, so a source/target
// pair yields up to three records, and the sustained rate is set by the
// single result port. Frames that yield nothing never occupy the back end.
// Depends on lbr_pkg, lbr_front, lbr_queue and lbr_back.
module lbr_branch_range_extractor #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [lbr_pkg::ADDR_W-1:0]  cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [lbr_pkg::ADDR_W-1:0]  s_frame_address,
    input  logic                        s_in_main_binary,
    input  logic                        s_skewed,
    input  logic                        s_sample_end,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [lbr_pkg::KIND_W-1:0]  m_record_kind,
    output logic [lbr_pkg::ADDR_W-1:0]  m_from_address,
    output logic [lbr_pkg::ADDR_W-1:0]  m_to_address,
    output logic                        m_last_result
);
    import lbr_pkg::*;

    logic [ADDR_W-1:0] skew_reg;
    logic [SPAN_W-1:0] span_reg;
    logic              push, pop, full, empty;
    job_t              push_job, head_job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skew_reg <= '0;
            span_reg <= SPAN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_SKEW: skew_reg <= cfg_data;
                CFG_SPAN: span_reg <= cfg_data[SPAN_W-1:0];
                default:  skew_reg <= skew_reg;
            endcase
        end
    end

    lbr_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_frame_address  (s_frame_address),
        .s_in_main_binary (s_in_main_binary),
        .s_skewed         (s_skewed),
        .s_sample_end     (s_sample_end),
        .skew_adjustment  (skew_reg),
        .queue_full       (full),
        .push             (push),
        .push_job         (push_job)
    );

    lbr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (full),
        .empty    (empty),
        .head_job (head_job)
    );

    lbr_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .job_valid      (!empty),
        .job            (head_job),
        .pop            (pop),
        .max_range_span (span_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_record_kind  (m_record_kind),
        .m_from_address (m_from_address),
        .m_to_address   (m_to_address),
        .m_last_result  (m_last_result)
    );

endmodule

FILE: rtl/lbr_front.sv
// Front end: accepts frames, applies skew, tracks per-sample state.
// Pushes one job per frame that yields records; depends on lbr_pkg.
module lbr_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [lbr_pkg::ADDR_W-1:0]  s_frame_address,
    input  logic                        s_in_main_binary,
    input  logic                        s_skewed,
    input  logic                        s_sample_end,
    input  logic [lbr_pkg::ADDR_W-1:0]  skew_adjustment,
    input  logic                        queue_full,
    output logic                        push,
    output lbr_pkg::job_t               push_job
);
    import lbr_pkg::*;

    logic              drop_reg, drop_next;
    logic              tphase_reg, tphase_next;
    logic [ADDR_W-1:0] pend_src_reg, pend_src_next;
    logic              pend_main_reg, pend_main_next;
    logic [ADDR_W-1:0] prev_src_reg, prev_src_next;
    logic              have_prev_reg, have_prev_next;
    logic              first_done_reg, first_done_next;

    logic              accept;
    logic [ADDR_W:0]   sum;
    logic              ovf;
    logic [ADDR_W-1:0] adj;
    logic              valid_pair;
    logic              clear;

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;

    assign sum = {1'b0, s_frame_address} + {1'b0, skew_adjustment};
    assign ovf = s_skewed && sum[ADDR_W];
    assign adj = s_skewed ? sum[ADDR_W-1:0] : s_frame_address;
    assign valid_pair = pend_main_reg && s_in_main_binary;

    always_comb begin
        drop_next       = drop_reg;
        tphase_next     = tphase_reg;
        pend_src_next   = pend_src_reg;
        pend_main_next  = pend_main_reg;
        prev_src_next   = prev_src_reg;
        have_prev_next  = have_prev_reg;
        first_done_next = first_done_reg;
        clear           = 1'b0;
        push            = 1'b0;
        push_job        = '{is_branch: 1'b0, single_kind: KIND_OVERFLOW, hot: 1'b0,
                            has_range: 1'b0, addr_a: s_frame_address, addr_b: adj,
                            addr_c: prev_src_reg};
        if (accept) begin
            if (drop_reg) begin
                clear = s_sample_end;
            end else if (!tphase_reg) begin
                if (s_in_main_binary && ovf) begin
                    push = 1'b1;
                    if (s_sample_end) clear = 1'b1;
                    else drop_next = 1'b1;
                end else if (s_sample_end) begin
                    push = 1'b1;
                    push_job.single_kind = KIND_ODD;
                    clear = 1'b1;
                end else begin
                    pend_src_next  = s_in_main_binary ? adj : '0;
                    pend_main_next = s_in_main_binary;
                    tphase_next    = 1'b1;
                end
            end else begin
                if (valid_pair && ovf) begin
                    push = 1'b1;
                    if (s_sample_end) clear = 1'b1;
                    else drop_next = 1'b1;
                end else begin
                    if (valid_pair) begin
                        push               = 1'b1;
                        push_job.is_branch = 1'b1;
                        push_job.hot       = !first_done_reg;
                        push_job.has_range = have_prev_reg;
                        push_job.addr_a    = pend_src_reg;
                    end
                    prev_src_next   = valid_pair ? pend_src_reg : '0;
                    have_prev_next  = valid_pair;
                    first_done_next = 1'b1;
                    tphase_next     = 1'b0;
                    pend_src_next   = '0;
                    pend_main_next  = 1'b0;
                    clear           = s_sample_end;
                end
            end
        end
        if (clear) begin
            drop_next       = 1'b0;
            tphase_next     = 1'b0;
            pend_src_next   = '0;
            pend_main_next  = 1'b0;
            prev_src_next   = '0;
            have_prev_next  = 1'b0;
            first_done_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drop_reg       <= 1'b0;
            tphase_reg     <= 1'b0;
            pend_src_reg   <= '0;
            pend_main_reg  <= 1'b0;
            prev_src_reg   <= '0;
            have_prev_reg  <= 1'b0;
            first_done_reg <= 1'b0;
        end else begin
            drop_reg       <= drop_next;
            tphase_reg     <= tphase_next;
            pend_src_reg   <= pend_src_next;
            pend_main_reg  <= pend_main_next;
            prev_src_reg   <= prev_src_next;
            have_prev_reg  <= have_prev_next;
            first_done_reg <= first_done_next;
        end
    end

endmodule

FILE: rtl/lbr_queue.sv
// Short job queue between front and back end.
// Stores lbr_pkg::job_t entries in a small circular buffer.
module lbr_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  lbr_pkg::job_t push_job,
    input  logic          pop,
    output logic          full,
    output logic          empty,
    output lbr_pkg::job_t head_job
);
    import lbr_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    job_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

FILE: rtl/lbr_back.sv
// Back end: expands queued jobs into records, one per cycle while m_ready allows.
// Checks range span and holds the result register; depends on lbr_pkg.
module lbr_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        job_valid,
    input  lbr_pkg::job_t               job,
    output logic                        pop,
    input  logic [lbr_pkg::SPAN_W-1:0]  max_range_span,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [lbr_pkg::KIND_W-1:0]  m_record_kind,
    output logic [lbr_pkg::ADDR_W-1:0]  m_from_address,
    output logic [lbr_pkg::ADDR_W-1:0]  m_to_address,
    output logic                        m_last_result
);
    import lbr_pkg::*;

    logic              m_valid_reg;
    kind_t             kind_reg, kind_next;
    logic [ADDR_W-1:0] from_reg, from_next;
    logic [ADDR_W-1:0] to_reg, to_next;
    logic              last_reg, last_next;
    logic [1:0]        step_reg;
    logic [1:0]        idx;
    logic [ADDR_W:0]   diff;
    logic              bogus;
    logic              load;

    // Range end minus begin; a borrow means the range is reversed.
    assign diff  = {1'b0, job.addr_c} - {1'b0, job.addr_b};
    assign bogus = diff[ADDR_W] || (diff[ADDR_W-1:0] > {{(ADDR_W-SPAN_W){1'b0}}, max_range_span});

    assign idx  = step_reg + {1'b0, !job.hot};
    assign load = job_valid && (!m_valid_reg || m_ready);
    assign pop  = load && last_next;

    always_comb begin
        kind_next = job.single_kind;
        from_next = job.addr_a;
        to_next   = '0;
        last_next = 1'b1;
        if (job.is_branch) begin
            case (idx)
                2'd0: begin
                    kind_next = KIND_HOT;
                    from_next = job.addr_b;
                    last_next = 1'b0;
                end
                2'd1: begin
                    kind_next = KIND_BRANCH;
                    from_next = job.addr_a;
                    to_next   = job.addr_b;
                    last_next = !job.has_range;
                end
                2'd2: begin
                    kind_next = bogus ? KIND_BOGUS : KIND_RANGE;
                    from_next = job.addr_b;
                    to_next   = job.addr_c;
                end
                default: begin
                    last_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg <= kind_next;
            from_reg <= from_next;
            to_reg   <= to_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            step_reg    <= '0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                step_reg    <= last_next ? 2'd0 : step_reg + 2'd1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_record_kind  = kind_reg;
    assign m_from_address = from_reg;
    assign m_to_address   = to_reg;
    assign m_last_result  = last_reg;

endmodule

FILE: tb/tb_top.sv
// Testbench for lbr_branch_range_extractor: drives branch-record frames and checks the
// emitted records against a cycle-free predictor of the source/target pairing rules.
// Depends on lbr_pkg and the block's RTL only.
module tb_top;
    import lbr_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned FRAMES_PER_PHASE = 45;
    localparam logic [ADDR_W-1:0] ALL_ONES = {ADDR_W{1'b1}};

    typedef struct {
        kind_t             kind;
        logic [ADDR_W-1:0] from_addr;
        logic [ADDR_W-1:0] to_addr;
        logic              last;
    } branch_record_t;

    class branch_record_tracker;
        logic [ADDR_W-1:0] skew_adj;
        logic [SPAN_W-1:0] span_limit;
        bit                in_target;
        logic [ADDR_W-1:0] held_source;
        bit                held_main;
        logic [ADDR_W-1:0] prev_source;
        bit                have_prev;
        bit                dropping;
        bit                first_pair_seen;
        branch_record_t    expected_records[$];
        int unsigned       errors;

        function new();
            skew_adj   = '0;
            span_limit = SPAN_RESET;
            errors     = 0;
            clear_sample();
        endfunction

        function void clear_sample();
            in_target       = 1'b0;
            held_source     = '0;
            held_main       = 1'b0;
            prev_source     = '0;
            have_prev       = 1'b0;
            dropping        = 1'b0;
            first_pair_seen = 1'b0;
        endfunction

        function void set_register(cfg_index_t idx, logic [ADDR_W-1:0] value);
            if (idx == CFG_SKEW) begin
                skew_adj = value;
            end else begin
                span_limit = value[SPAN_W-1:0];
            end
        endfunction

        function bit adjust(logic [ADDR_W-1:0] addr, bit skw, output logic [ADDR_W-1:0] res);
            res = addr;
            if (!skw) begin
                return 1'b1;
            end
            if (addr > ALL_ONES - skew_adj) begin
                return 1'b0;
            end
            res = addr + skew_adj;
            return 1'b1;
        endfunction

        function void push(kind_t kind, logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] b, bit last);
            branch_record_t rec;
            rec.kind      = kind;
            rec.from_addr = a;
            rec.to_addr   = b;
            rec.last      = last;
            expected_records.insert(expected_records.size(), rec);
        endfunction

        // Overflow: one record, then drop everything up to the end of the sample.
        function void flag_overflow(logic [ADDR_W-1:0] addr, bit last_frame);
            push(KIND_OVERFLOW, addr, '0, 1'b1);
            if (last_frame) begin
                clear_sample();
            end else begin
                dropping = 1'b1;
            end
        endfunction

        function void note_frame(logic [ADDR_W-1:0] addr, bit main_bin, bit skw,
                                 bit last_frame);
            logic [ADDR_W-1:0] adj;
            bit                valid;
            adj = '0;
            if (dropping) begin
                if (last_frame) begin
                    clear_sample();
                end
                return;
            end
            if (!in_target) begin
                if (main_bin && !adjust(addr, skw, adj)) begin
                    flag_overflow(addr, last_frame);
                    return;
                end
                if (last_frame) begin
                    push(KIND_ODD, addr, '0, 1'b1);
                    clear_sample();
                    return;
                end
                held_source = main_bin ? adj : '0;
                held_main   = main_bin;
                in_target   = 1'b1;
                return;
            end
            valid = held_main && main_bin;
            if (valid && !adjust(addr, skw, adj)) begin
                flag_overflow(addr, last_frame);
                return;
            end
            if (valid) begin
                if (!first_pair_seen) begin
                    push(KIND_HOT, adj, '0, 1'b0);
                end
                push(KIND_BRANCH, held_source, adj, 1'b0);
                if (have_prev) begin
                    if (prev_source < adj || prev_source - adj > {32'b0, span_limit}) begin
                        push(KIND_BOGUS, adj, prev_source, 1'b0);
                    end else begin
                        push(KIND_RANGE, adj, prev_source, 1'b0);
                    end
                end
                expected_records[expected_records.size()-1].last = 1'b1;
            end
            prev_source     = valid ? held_source : '0;
            have_prev       = valid;
            first_pair_seen = 1'b1;
            in_target       = 1'b0;
            held_source     = '0;
            held_main       = 1'b0;
            if (last_frame) begin
                clear_sample();
            end
        endfunction

        function void check_record(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] a,
                                   logic [ADDR_W-1:0] b, logic last);
            branch_record_t exp_rec;
            if (expected_records.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected record: kind %0d from %h to %h last %b",
                             kind, a, b, last);
                end
                return;
            end
            exp_rec = expected_records.pop_front();
            if (exp_rec.kind !== kind || exp_rec.from_addr !== a || exp_rec.to_addr !== b ||
                exp_rec.last !== last) begin
                errors++;
                if (errors <= 10) begin
                    $display("record differs: expected kind %0d from %h to %h last %b",
                             exp_rec.kind, exp_rec.from_addr, exp_rec.to_addr, exp_rec.last);
                    $display("                got      kind %0d from %h to %h last %b",
                             kind, a, b, last);
                end
            end
        endfunction

        function int unsigned pending();
            return expected_records.size();
        endfunction

        function bit clean();
            if (expected_records.size() != 0) begin
                $display("%0d expected records never arrived", expected_records.size());
            end
            return errors == 0 && expected_records.size() == 0;
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_wr_en;
    logic              cfg_index;
    logic [ADDR_W-1:0] cfg_data;
    logic              s_valid;
    logic              s_ready;
    logic [ADDR_W-1:0] s_frame_address;
    logic              s_in_main_binary;
    logic              s_skewed;
    logic              s_sample_end;
    logic              m_valid;
    logic              m_ready;
    logic [KIND_W-1:0] m_record_kind;
    logic [ADDR_W-1:0] m_from_address;
    logic [ADDR_W-1:0] m_to_address;
    logic              m_last_result;

    branch_record_tracker tracker;
    bit                   steady;
    bit                   timed_out;
    int unsigned          frames_sent;
    int unsigned          ready_left;
    int unsigned          quiet_cycles;

    lbr_branch_range_extractor dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_frame_address  (s_frame_address),
        .s_in_main_binary (s_in_main_binary),
        .s_skewed         (s_skewed),
        .s_sample_end     (s_sample_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_record_kind    (m_record_kind),
        .m_from_address   (m_from_address),
        .m_to_address     (m_to_address),
        .m_last_result    (m_last_result)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 25);
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        return {$urandom, $urandom};
    endfunction

    // Frame and record transfers are both taken here so their order within a step is fixed.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                frames_sent++;
                tracker.note_frame(s_frame_address, s_in_main_binary, s_skewed, s_sample_end);
            end
            if (m_valid && m_ready) begin
                tracker.check_record(m_record_kind, m_from_address, m_to_address,
                                     m_last_result);
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (steady) begin
            m_ready <= 1'b1;
        end else if (ready_left > 0) begin
            ready_left--;
        end else if (m_ready) begin
            ready_left = pick_gap();
            if (ready_left != 0) begin
                m_ready <= 1'b0;
                ready_left--;
            end else begin
                ready_left = $urandom_range(0, 6);
            end
        end else begin
            m_ready <= 1'b1;
            ready_left = $urandom_range(0, 8);
        end
    end

    // Called and returns at a falling edge; valid stays high into the next frame if no gap.
    task automatic send_frame(logic [ADDR_W-1:0] addr, bit main_bin, bit skw, bit last_frame);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_frame_address  <= addr;
        s_in_main_binary <= main_bin;
        s_skewed         <= skw;
        s_sample_end     <= last_frame;
        s_valid          <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_register(cfg_index_t idx, logic [ADDR_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        tracker.set_register(idx, value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic send_sample();
        int unsigned       shape;
        int unsigned       count;
        logic [ADDR_W-1:0] base;
        bit                skw_all;
        shape = $urandom_range(0, 9);
        if (shape >= 8) begin
            // noise: fully random fields
            count = $urandom_range(1, 6);
            for (int i = 0; i < count; i++) begin
                send_frame(rand_addr(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           i == count - 1);
            end
            return;
        end
        case ($urandom_range(0, 7))
            0: base = {32'hFFFF_FFFF, 16'hFFFF, 16'($urandom)};
            1: base = 64'($urandom_range(0, 16'hFFFF));
            default: base = rand_addr();
        endcase
        count   = $urandom_range(1, 4);
        skw_all = 1'($urandom_range(0, 1));
        for (int i = 0; i < count; i++) begin
            send_frame(base + 64'($urandom_range(0, 12288)), $urandom_range(0, 15) != 0,
                       ($urandom_range(0, 7) == 0) ^ skw_all, 1'b0);
            send_frame(base + 64'($urandom_range(0, 12288)), $urandom_range(0, 15) != 0,
                       ($urandom_range(0, 7) == 0) ^ skw_all, shape != 7 && i == count - 1);
        end
        if (shape == 7) begin
            // close on a source frame: odd frame count
            send_frame(base + 64'($urandom_range(0, 12288)), $urandom_range(0, 15) != 0,
                       skw_all, 1'b1);
        end
    endtask

    task automatic run_stimulus();
        int unsigned goal;
        // reset settings: skew 0, span 1 MiB
        send_frame(64'h0000_0000_4000_1000, 1, 0, 0);
        send_frame(64'h0000_0000_4000_0000, 1, 1, 0);
        send_frame(64'h0000_0000_4000_0800, 1, 0, 0);
        send_frame(64'h0000_0000_4000_0F00, 1, 0, 0);
        send_frame(64'h0000_0000_3FFF_0000, 1, 0, 0);
        send_frame(64'h0000_0000_4000_0900, 1, 0, 0);
        send_frame(64'h0000_0000_5000_0000, 1, 0, 0);
        send_frame(64'h0000_0000_3FEF_0000, 1, 0, 0);
        send_frame(64'h0000_0000_0000_1234, 1, 0, 0);
        send_frame(64'h0000_0000_4FEF_FFFF, 1, 0, 1);
        send_frame(ALL_ONES, 1, 0, 0);
        send_frame(64'h0, 1, 0, 0);
        send_frame(64'h10, 0, 0, 0);
        send_frame(64'h20, 1, 0, 0);
        send_frame(64'h30, 1, 0, 0);
        send_frame(64'h40, 1, 0, 1);
        send_frame(64'h0000_0000_DEAD_BEEF, 1, 0, 1);
        send_frame(64'h77, 0, 1, 1);
        wait_idle();

        write_register(CFG_SKEW, ALL_ONES);
        write_register(CFG_SPAN, {$urandom, 32'h0});
        send_frame(64'h1, 1, 1, 0);
        send_frame(rand_addr(), 1, 0, 0);
        send_frame(rand_addr(), 1, 1, 1);
        send_frame(64'h0, 1, 1, 0);
        send_frame(ALL_ONES, 0, 1, 0);
        send_frame(64'h5, 1, 1, 1);
        send_frame(64'h7, 1, 0, 0);
        send_frame(64'h2, 1, 1, 1);

        goal = frames_sent;
        for (int phase = 0; phase < 5; phase++) begin
            wait_idle();
            steady = (phase == 0);
            case (phase)
                0: begin
                    write_register(CFG_SKEW, 64'h0);
                    write_register(CFG_SPAN, {$urandom, 32'hFFFF_FFFF});
                end
                1: begin
                    write_register(CFG_SKEW, 64'($urandom_range(1, 16'hFFFF)));
                    write_register(CFG_SPAN, {$urandom, 32'($urandom_range(0, 16'h2000))});
                end
                2: begin
                    write_register(CFG_SKEW, rand_addr());
                    write_register(CFG_SPAN, {$urandom, $urandom});
                end
                3: begin
                    write_register(CFG_SKEW, ALL_ONES);
                    write_register(CFG_SPAN, {$urandom, 32'h0});
                end
                default: begin
                    write_register(CFG_SKEW, 64'($urandom_range(1, 255)));
                    write_register(CFG_SPAN, {$urandom, SPAN_RESET});
                end
            endcase
            goal += FRAMES_PER_PHASE;
            while (frames_sent < goal) send_sample();
        end
        wait_idle();
        repeat (16) @(negedge aclk);
    endtask

    initial begin
        tracker          = new();
        aresetn          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = CFG_SKEW;
        cfg_data         = '0;
        s_valid          = 1'b0;
        s_frame_address  = '0;
        s_in_main_binary = 1'b0;
        s_skewed         = 1'b0;
        s_sample_end     = 1'b0;
        m_ready          = 1'b0;
        steady           = 1'b0;
        timed_out        = 1'b0;
        frames_sent      = 0;
        ready_left       = 0;
        quiet_cycles     = 0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        fork
            run_stimulus();
            begin
                // end the run if no transfer happens on either side for too long
                while (quiet_cycles < WATCHDOG_LIMIT) begin
                    @(posedge aclk);
                    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                        quiet_cycles = 0;
                    end else begin
                        quiet_cycles++;
                    end
                end
                timed_out = 1'b1;
            end
        join_any
        if (!timed_out && tracker.clean()) begin
            $display("lbr_branch_range_extractor: match");
        end else begin
            $display("lbr_branch_range_extractor: mismatch");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/lbr_pkg.sv
rtl/lbr_front.sv
rtl/lbr_queue.sv
rtl/lbr_back.sv
rtl/lbr_branch_range_extractor.sv
tb/tb_top.sv
